FILE: design/tdhs_pkg.sv
// Shared types, codes and constants of the time-domain harmonic scaling compressor.
package tdhs_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Widths of the shared restoring divider.
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 12;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_PULL = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTREADY = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_TLEN  = 2'd1;
    localparam logic [1:0] REG_MINP  = 2'd2;
    localparam logic [1:0] REG_MAXP  = 2'd3;

    localparam logic [10:0] RATE_RST = 11'd512;
    localparam logic [9:0]  TLEN_RST = 10'd160;
    localparam logic [9:0]  MINP_RST = 10'd80;
    localparam logic [9:0]  MAXP_RST = 10'd320;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_COR_ADR,
        S_COR_RD,
        S_COR_MUL,
        S_COR_ACC,
        S_Q_DIV,
        S_Q_WAIT,
        S_PULL,
        S_XF_RD,
        S_XF_MA,
        S_XF_MB,
        S_XF_SUM,
        S_XF_WAIT,
        S_CP_RD,
        S_CP_DATA
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

FILE: design/tdhs_if.sv
// Handshake channel interfaces: request, result and configuration write.
interface tdhs_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    modport source (output valid, output req_type, output sample_in, input ready);
    modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

interface tdhs_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [1:0]                    status;
    modport source (output valid, output sample_out, output status, input ready);
    modport sink   (input valid, input sample_out, input status, output ready);
endinterface

interface tdhs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tdhs_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module tdhs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdhs_pkg::t_div_req i_req,
    output tdhs_pkg::t_div_rsp o_rsp
);
    import tdhs_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_dvs, n_dvs;
    logic [DIV_DW:0]   c_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        c_trial = {r_rem, r_quo[DIV_NW-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DIV_NW);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (c_trial >= {1'b0, r_dvs}) begin
                c_trial = c_trial - {1'b0, r_dvs};
                n_quo   = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_quo   = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_rem = c_trial[DIV_DW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: design/autocorrelation_time_compressor.sv
// Top level of the time-domain harmonic scaling compressor.
// Each request beat yields exactly one result beat. Push, end-of-input and unknown
// requests go straight to the result stage and wait there only for the result
// register to drain. A pull that copies a stored sample reads it from the window
// store; a cross-faded pull also waits on the shared bit-serial divider. A pull that
// opens a new frame first runs the lag search on the single shared multiplier, with
// address, read, multiply and accumulate steps per multiply-accumulate, and then
// the copy length division when the rate is above 256. The window memory needs no
// clearing pass, and the block is ready straight out of reset.
module autocorrelation_time_compressor #(
    parameter int WINDOW_DEPTH = tdhs_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = tdhs_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdhs_in_if.sink     i_req,
    tdhs_out_if.source  o_res,
    tdhs_cfg_if.sink    i_cfg
);
    import tdhs_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int HW   = AW + 2;
    localparam int MW   = ((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) + 1;
    localparam int PW   = 2 * MW;
    localparam int ACCW = 2 * SAMPLE_BITS + 10;
    localparam logic [13:0] PCAP = 14'((WINDOW_DEPTH - 1) / 2);
    localparam logic [AW+2:0] DEPTH_W = (AW+3)'(WINDOW_DEPTH);
    localparam logic [AW+2:0] DEPTH_E = (AW+3)'(WINDOW_DEPTH);

    // Reduce a store offset sum (below four depths) to a store address.
    function automatic logic [AW-1:0] f_wrap(input logic [AW+2:0] x);
        logic [AW+2:0] y;
        y = x;
        for (int i = 0; i < 3; i++) begin
            if (y >= DEPTH_W) begin
                y = y - DEPTH_W;
            end
        end
        return y[AW-1:0];
    endfunction

    // Configuration registers.
    logic [10:0] r_rate;
    logic [9:0]  r_tlen, r_minp, r_maxp;

    // Stream state.
    logic [HW-1:0] r_held, n_held;
    logic [AW-1:0] r_faddr, n_faddr;
    logic [9:0]    r_period, n_period;
    logic [10:0]   r_copy, n_copy;
    logic [10:0]   r_flen, n_flen;
    logic [10:0]   r_oidx, n_oidx;
    logic          r_frdy, n_frdy;
    logic          r_ended, n_ended;

    // Sequencer and datapath.
    t_state                        r_state, n_state;
    logic [9:0]                    r_m, n_m;
    logic [9:0]                    r_n, n_n;
    logic signed [ACCW-1:0]        r_acc, n_acc;
    logic signed [ACCW-1:0]        r_best, n_best;
    logic signed [PW-1:0]          r_prod, n_prod;
    logic signed [PW:0]            r_num, n_num;
    logic                          r_neg, n_neg;
    logic [HW-1:0]                 r_off0, n_off0;
    logic [HW-1:0]                 r_off1, n_off1;
    logic signed [SAMPLE_BITS-1:0] r_q0, r_q1;
    logic signed [SAMPLE_BITS-1:0] r_rsmp, n_rsmp;
    logic [1:0]                    r_rst, n_rst;
    logic                          r_ov, n_ov;
    logic signed [SAMPLE_BITS-1:0] r_osmp, n_osmp;
    logic [1:0]                    r_ostat, n_ostat;

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_DEPTH];

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Clamped lag bounds, taken from the live registers.
    logic [9:0]  c_pmax, c_pmin, c_tl;
    logic [10:0] c_need;
    logic [10:0] c_d;
    logic        c_rate_hi;
    logic [11:0] c_oldest;
    logic        c_in_acc, c_load;
    logic        c_we;
    logic [AW-1:0] c_waddr, c_ra0, c_ra1;
    logic signed [MW-1:0] c_ma, c_mb;
    logic signed [ACCW-1:0] c_sum;
    logic signed [PW:0]   c_xnum;
    logic [PW:0]          c_xabs;
    logic signed [DIV_NW:0] c_xv;
    logic [10:0]          c_qv;
    logic [10:0]          c_oidx1;
    logic [11:0]          c_adv;
    logic [10:0]          c_pmk;

    always_comb begin
        if (r_maxp == 10'd0) begin
            c_pmax = 10'd1;
        end else if ({4'd0, r_maxp} > PCAP) begin
            c_pmax = PCAP[9:0];
        end else begin
            c_pmax = r_maxp;
        end
        if (r_minp == 10'd0) begin
            c_pmin = 10'd1;
        end else if (r_minp > c_pmax) begin
            c_pmin = c_pmax;
        end else begin
            c_pmin = r_minp;
        end
        c_tl = (r_tlen > c_pmax) ? c_pmax : r_tlen;
    end

    assign c_need    = {c_pmax, 1'b0} + 11'd1;
    assign c_rate_hi = (r_rate > 11'd256);
    assign c_d       = r_rate - 11'd256;
    assign c_in_acc  = i_req.valid && i_req.ready;
    assign c_load    = (r_state == S_FIN) && (!r_ov || o_res.ready);
    assign c_oidx1   = r_oidx + 11'd1;
    assign c_adv     = {2'd0, r_period} + {1'b0, r_copy};
    assign c_pmk     = {1'b0, r_period} - r_oidx;
    assign c_oldest  = !r_frdy ? 12'd0 :
                       ((r_oidx < {1'b0, r_period}) ? {1'b0, r_oidx}
                                                    : ({2'd0, r_period} + {1'b0, r_oidx}));
    assign c_waddr = f_wrap((AW+3)'(r_faddr) + (AW+3)'(r_held));
    assign c_ra0   = f_wrap((AW+3)'(r_faddr) + (AW+3)'(r_off0));
    assign c_ra1   = f_wrap((AW+3)'(r_faddr) + (AW+3)'(r_off1));

    // The one shared multiplier; its product is always registered.
    always_comb begin
        c_ma = '0;
        c_mb = '0;
        unique case (r_state)
            S_COR_MUL: begin
                c_ma = MW'(r_q0);
                c_mb = MW'(r_q1);
            end
            S_XF_MA: begin
                c_ma = MW'($signed({1'b0, c_pmk}));
                c_mb = MW'(r_q0);
            end
            S_XF_MB: begin
                c_ma = MW'($signed({1'b0, r_oidx}));
                c_mb = MW'(r_q1);
            end
            default: begin
                c_ma = '0;
                c_mb = '0;
            end
        endcase
    end

    assign c_sum  = r_acc + ACCW'(r_prod);
    assign c_xnum = r_num + (PW+1)'(r_prod);
    assign c_xabs = c_xnum[PW] ? (PW+1)'(-c_xnum) : (PW+1)'(c_xnum);
    assign c_xv   = r_neg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    assign c_qv   = (div_rsp.quot > DIV_NW'({c_pmax, 1'b0})) ? {c_pmax, 1'b0}
                                                           : div_rsp.quot[10:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (c_in_acc) begin
                    if (i_req.req_type == REQ_PULL) begin
                        if (!r_frdy && ({{(HW-11){1'b0}}, c_need} <= r_held)) begin
                            n_state = (c_tl == 10'd0) ? S_Q_DIV : S_COR_ADR;
                        end else begin
                            n_state = S_PULL;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN:     n_state = c_load ? S_IDLE : S_FIN;
            S_COR_ADR: n_state = S_COR_RD;
            S_COR_RD:  n_state = S_COR_MUL;
            S_COR_MUL: n_state = S_COR_ACC;
            S_COR_ACC: begin
                if (r_n == c_tl - 10'd1 && r_m == c_pmax) begin
                    n_state = S_Q_DIV;
                end else begin
                    n_state = S_COR_ADR;
                end
            end
            S_Q_DIV:   n_state = c_rate_hi ? S_Q_WAIT : S_PULL;
            S_Q_WAIT:  n_state = div_rsp.done ? S_PULL : S_Q_WAIT;
            S_PULL: begin
                if (!r_frdy) begin
                    n_state = S_FIN;
                end else if (r_oidx < {1'b0, r_period}) begin
                    n_state = S_XF_RD;
                end else if ((HW'(r_period) + HW'(r_oidx)) < r_held) begin
                    n_state = S_CP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_XF_RD:   n_state = S_XF_MA;
            S_XF_MA:   n_state = S_XF_MB;
            S_XF_MB:   n_state = S_XF_SUM;
            S_XF_SUM:  n_state = S_XF_WAIT;
            S_XF_WAIT: n_state = div_rsp.done ? S_FIN : S_XF_WAIT;
            S_CP_RD:   n_state = S_CP_DATA;
            S_CP_DATA: n_state = S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and stream state updates.
    always_comb begin
        n_held   = r_held;
        n_faddr  = r_faddr;
        n_period = r_period;
        n_copy   = r_copy;
        n_flen   = r_flen;
        n_oidx   = r_oidx;
        n_frdy   = r_frdy;
        n_ended  = r_ended;
        n_m      = r_m;
        n_n      = r_n;
        n_acc    = r_acc;
        n_best   = r_best;
        n_prod   = PW'(c_ma * c_mb);
        n_num    = r_num;
        n_neg    = r_neg;
        n_off0   = r_off0;
        n_off1   = r_off1;
        n_rsmp   = r_rsmp;
        n_rst    = r_rst;
        c_we     = 1'b0;
        div_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                n_rsmp = '0;
                n_rst  = ST_OK;
                if (c_in_acc) begin
                    unique case (i_req.req_type)
                        REQ_PUSH: begin
                            if (r_ended) begin
                                n_rst = ST_FINISHED;
                            end else if ((AW+3)'(r_held) >= (AW+3)'(c_oldest) + DEPTH_E) begin
                                n_rst = ST_FULL;
                            end else begin
                                c_we   = 1'b1;
                                n_held = r_held + HW'(1);
                            end
                        end
                        REQ_PULL: begin
                            // A frame decision starts with the lag search state.
                            n_m      = c_pmin;
                            n_n      = '0;
                            n_acc    = '0;
                            n_best   = '0;
                            n_period = (!r_frdy) ? c_pmin : r_period;
                        end
                        REQ_END: n_ended = 1'b1;
                        default: n_rst = ST_OK;
                    endcase
                end
            end
            S_COR_ADR: begin
                n_off0 = HW'(r_n);
                n_off1 = HW'(r_m) + HW'(r_n);
            end
            S_COR_ACC: begin
                if (r_n == c_tl - 10'd1) begin
                    if (c_sum > r_best) begin
                        n_best   = c_sum;
                        n_period = r_m;
                    end
                    n_acc = '0;
                    n_n   = '0;
                    n_m   = r_m + 10'd1;
                end else begin
                    n_acc = c_sum;
                    n_n   = r_n + 10'd1;
                end
            end
            S_Q_DIV: begin
                if (c_rate_hi) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NW'({r_period, 9'd0}) + DIV_NW'(c_d);
                    div_req.divisor  = {c_d, 1'b0};
                end else begin
                    n_copy = {c_pmax, 1'b0};
                    n_flen = ({c_pmax, 1'b0} > {1'b0, r_period}) ? {c_pmax, 1'b0}
                                                                 : {1'b0, r_period};
                    n_oidx = '0;
                    n_frdy = 1'b1;
                end
            end
            S_Q_WAIT: begin
                if (div_rsp.done) begin
                    n_copy = c_qv;
                    n_flen = (c_qv > {1'b0, r_period}) ? c_qv : {1'b0, r_period};
                    n_oidx = '0;
                    n_frdy = 1'b1;
                end
            end
            S_PULL: begin
                n_off0 = HW'(r_oidx);
                n_off1 = HW'(r_period) + HW'(r_oidx);
                n_rst  = r_ended ? ST_FINISHED : ST_NOTREADY;
            end
            S_XF_MB: n_num = (PW+1)'(r_prod);
            S_XF_SUM: begin
                n_neg            = c_xnum[PW];
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(c_xabs) + DIV_NW'(r_period[9:1]);
                div_req.divisor  = DIV_DW'(r_period);
            end
            S_XF_WAIT, S_CP_DATA: begin
                if (r_state == S_CP_DATA || div_rsp.done) begin
                    n_rst  = ST_OK;
                    n_rsmp = (r_state == S_CP_DATA) ? r_q1 : c_xv[SAMPLE_BITS-1:0];
                    // Step through the frame; at its end move the frame start on.
                    if (c_oidx1 >= r_flen) begin
                        n_held  = r_held - HW'(c_adv);
                        n_faddr = f_wrap((AW+3)'(r_faddr) + (AW+3)'(c_adv));
                        n_frdy  = 1'b0;
                        n_oidx  = '0;
                    end else begin
                        n_oidx  = c_oidx1;
                    end
                end
            end
            default: n_rst = r_rst;
        endcase
    end

    // Result register: a finished result waits here until it is taken.
    always_comb begin
        n_ov    = r_ov;
        n_osmp  = r_osmp;
        n_ostat = r_ostat;
        if (c_load) begin
            n_ov    = 1'b1;
            n_osmp  = r_rsmp;
            n_ostat = r_rst;
        end else if (o_res.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_tlen   <= TLEN_RST;
            r_minp   <= MINP_RST;
            r_maxp   <= MAXP_RST;
            r_held   <= '0;
            r_faddr  <= '0;
            r_period <= '0;
            r_copy   <= '0;
            r_flen   <= '0;
            r_oidx   <= '0;
            r_frdy   <= 1'b0;
            r_ended  <= 1'b0;
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_RATE: r_rate <= i_cfg.data;
                    REG_TLEN: r_tlen <= i_cfg.data[9:0];
                    REG_MINP: r_minp <= i_cfg.data[9:0];
                    REG_MAXP: r_maxp <= i_cfg.data[9:0];
                    default:  r_rate <= r_rate;
                endcase
            end
            r_held   <= n_held;
            r_faddr  <= n_faddr;
            r_period <= n_period;
            r_copy   <= n_copy;
            r_flen   <= n_flen;
            r_oidx   <= n_oidx;
            r_frdy   <= n_frdy;
            r_ended  <= n_ended;
            r_state  <= n_state;
            r_ov     <= n_ov;
        end
        r_m     <= n_m;
        r_n     <= n_n;
        r_acc   <= n_acc;
        r_best  <= n_best;
        r_prod  <= n_prod;
        r_num   <= n_num;
        r_neg   <= n_neg;
        r_off0  <= n_off0;
        r_off1  <= n_off1;
        r_rsmp  <= n_rsmp;
        r_rst   <= n_rst;
        r_osmp  <= n_osmp;
        r_ostat <= n_ostat;
    end

    // Window store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= i_req.sample_in;
        end
        r_q0 <= $signed(r_mem[c_ra0]);
        r_q1 <= $signed(r_mem[c_ra1]);
    end

    tdhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_ov;
    assign o_res.sample_out = r_osmp;
    assign o_res.status     = r_ostat;

    a_oidx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frdy |-> (r_oidx < r_flen))
        else $error("output index ran past the frame length");

    a_idle_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frdy |-> (r_oidx == 11'd0))
        else $error("output index left nonzero outside a frame");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_Q_WAIT || r_state == S_XF_WAIT))
        else $error("divider finished while nobody waited for it");

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frdy |-> (r_period != 10'd0))
        else $error("frame open with a zero period");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !c_load) |=> (r_state == S_FIN && r_ov))
        else $error("finished result lost while the output stalled");

endmodule

FILE: bench/autocorrelation_time_compressor_test.sv
// Self-checking testbench of the time-domain harmonic scaling compressor.
`timescale 1ns / 1ps

module autocorrelation_time_compressor_test;
    import tdhs_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int CYC_LIMIT = 4_000_000;

    typedef struct {
        logic signed [15:0] sample;
        logic [1:0]         status;
    } t_result;

    // The scoreboard carries its own copy of the compressor state and
    // predicts one result beat for every accepted request beat.
    class tdhs_scoreboard;
        logic signed [15:0] window [DEPTH];
        int unsigned received, frame_start, frame_addr;
        int unsigned period, copy_len, out_len, out_idx;
        bit          frame_ready, ended;
        int unsigned rate, tlen, minp, maxp;
        t_result     pending[$];
        int          errors, checked, n_push, n_pull, n_full, n_frames;

        function new();
            foreach (window[i]) window[i] = '0;
            rate = RATE_RST;
            tlen = TLEN_RST;
            minp = MINP_RST;
            maxp = MAXP_RST;
        endfunction

        function longint tap(int unsigned off);
            return longint'(window[(frame_addr + off) % DEPTH]);
        endfunction

        function int unsigned lag_ceiling();
            int unsigned m;
            m = maxp;
            if (m < 1) m = 1;
            if (m > (DEPTH - 1) / 2) m = (DEPTH - 1) / 2;
            return m;
        endfunction

        // Lag search followed by the copy length of the new frame.
        function void open_frame();
            int unsigned hi, lo, tl, q, d;
            longint best, acc;
            hi = lag_ceiling();
            lo = minp;
            tl = tlen;
            best = 0;
            if (lo < 1) lo = 1;
            if (lo > hi) lo = hi;
            if (tl > hi) tl = hi;
            period = lo;
            for (int unsigned m = lo; m <= hi; m++) begin
                acc = 0;
                for (int unsigned n = 0; n < tl; n++) acc += tap(n) * tap(m + n);
                if (acc > best) begin
                    best = acc;
                    period = m;
                end
            end
            if (rate > 256) begin
                d = rate - 256;
                q = (512 * period + d) / (2 * d);
                if (q > 2 * hi) q = 2 * hi;
            end else begin
                q = 2 * hi;
            end
            copy_len = q;
            out_len = (q > period) ? q : period;
            out_idx = 0;
            frame_ready = 1;
            n_frames++;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                REG_RATE: rate = val;
                REG_TLEN: tlen = val[9:0];
                REG_MINP: minp = val[9:0];
                REG_MAXP: maxp = val[9:0];
            endcase
        endfunction

        function void note_request(logic [1:0] req, logic signed [15:0] smp);
            t_result     r;
            int unsigned held, oldest;
            longint      p, k, num, v;
            r.sample = '0;
            r.status = ST_OK;
            held = received - frame_start;
            if (req == REQ_PUSH) begin
                n_push++;
                oldest = 0;
                if (frame_ready) oldest = (out_idx < period) ? out_idx : period + out_idx;
                if (ended) begin
                    r.status = ST_FINISHED;
                end else if (held - oldest >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    window[(frame_addr + held) % DEPTH] = smp;
                    received++;
                end
            end else if (req == REQ_PULL) begin
                n_pull++;
                if (!frame_ready && held >= 2 * lag_ceiling() + 1) open_frame();
                if (!frame_ready) begin
                    r.status = ended ? ST_FINISHED : ST_NOTREADY;
                end else if (out_idx < period || period + out_idx < held) begin
                    if (out_idx < period) begin
                        // Cross-fade, rounded to nearest with ties away from zero.
                        p = period;
                        k = out_idx;
                        num = (p - k) * tap(out_idx) + k * tap(period + out_idx);
                        v = (num >= 0) ? (num + p / 2) / p : -((-num + p / 2) / p);
                    end else begin
                        v = tap(period + out_idx);
                    end
                    r.sample = v[15:0];
                    out_idx++;
                    if (out_idx >= out_len) begin
                        frame_start += period + copy_len;
                        frame_addr = (frame_addr + period + copy_len) % DEPTH;
                        frame_ready = 0;
                        out_idx = 0;
                    end
                end else begin
                    r.status = ended ? ST_FINISHED : ST_NOTREADY;
                end
            end else if (req == REQ_END) begin
                ended = 1;
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch after %0d results: %s", checked, what);
            errors++;
        endtask

        task check_result(logic signed [15:0] smp, logic [1:0] st);
            t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat sample %0d status %0d", smp, st));
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, predicted %0d", st, e.status));
            if (smp !== e.sample)
                report($sformatf("sample %0d, predicted %0d", smp, e.sample));
            checked++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #10 i_clk = ~i_clk;

    tdhs_in_if  #(16) req_if();
    tdhs_out_if #(16) res_if();
    tdhs_cfg_if       cfg_if();

    autocorrelation_time_compressor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    tdhs_scoreboard sb = new();
    bit             steady;     // When set, neither side inserts gaps.
    bit             hold_off;   // Long receiver stall, owned by its own process.
    int             cycles;
    logic signed [15:0] pattern [64];
    int             pat_len, pat_pos;

    initial begin
        req_if.valid = 0;
        req_if.req_type = REQ_PUSH;
        req_if.sample_in = '0;
        res_if.ready = 0;
        cfg_if.valid = 0;
        cfg_if.index = REG_RATE;
        cfg_if.data = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly no gap, some short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls plus the long hold-off window.
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off || stall > 0) begin
                res_if.ready = 0;
                if (stall > 0) stall--;
            end else begin
                res_if.ready = 1;
                if ($urandom_range(0, 7) == 0) stall = gap_len();
            end
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.sample_out, res_if.status);
        end
    end

    // Once 150 results have been checked the receiver holds off while
    // requests keep coming, so the block backs up onto its request port.
    initial begin
        hold_off = 0;
        wait (sb.checked >= 150);
        @(posedge i_clk);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    task automatic send_req(logic [1:0] req, logic signed [15:0] smp);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_if.valid = 0;
            repeat (g) @(negedge i_clk);
        end
        req_if.valid = 1;
        req_if.req_type = req;
        req_if.sample_in = smp;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(req, smp);
        @(negedge i_clk);
        req_if.valid = 0;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [10:0] val);
        cfg_if.valid = 1;
        cfg_if.index = idx;
        cfg_if.data = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_if.valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A fresh quasi-periodic waveform, so that the lag search finds real peaks.
    task automatic new_phase(int unsigned rate, int unsigned tl, int unsigned lo,
                             int unsigned hi);
        drain();
        cfg_write(REG_RATE, 11'(rate));
        cfg_write(REG_TLEN, 11'(tl));
        cfg_write(REG_MINP, 11'(lo));
        cfg_write(REG_MAXP, 11'(hi));
        pat_len = $urandom_range(2, 64);
        pat_pos = 0;
        foreach (pattern[i]) pattern[i] = 16'($urandom_range(0, 65535));
        steady = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic signed [15:0] next_sample();
        int r;
        r = $urandom_range(0, 19);
        pat_pos++;
        if (r == 0) return 16'sh7FFF;
        if (r == 1) return 16'sh8000;
        if (r < 4) return 16'($urandom_range(0, 65535));
        return 16'(int'(pattern[pat_pos % pat_len]) + int'($urandom_range(0, 63)) - 32);
    endfunction

    task automatic random_mix(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_req(REQ_PUSH, next_sample());
            else if (r < 98) send_req(REQ_PULL, '0);
            else send_req(2'd3, 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        steady = 0;
        pat_len = 8;
        pat_pos = 0;
        foreach (pattern[i]) pattern[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Reset settings: too little input for a frame, so pulls are not ready.
        send_req(REQ_PULL, '0);
        send_req(REQ_PUSH, 16'sh7FFF);
        send_req(REQ_PUSH, 16'sh8000);
        send_req(REQ_PUSH, 16'sh0000);
        send_req(REQ_PUSH, 16'shFFFF);
        send_req(2'd3, 16'sh5A5A);
        send_req(REQ_PULL, '0);

        // Smallest lags, lowest rate of the normal range.
        new_phase(384, 8, 2, 3);
        repeat (8) send_req(REQ_PUSH, next_sample());
        repeat (6) send_req(REQ_PULL, '0);
        random_mix(90);

        // Rate at or below unity with zero template, zero min and max of one:
        // the bounds clamp and the copy length saturates.
        new_phase(256, 0, 0, 1);
        random_mix(50);

        // Highest rate of the normal range.
        new_phase(1024, 16, 4, 24);
        random_mix(80);

        // Template longer than the max lag and min above max both get clamped.
        new_phase(2047, 50, 30, 20);
        random_mix(60);

        new_phase(600, 12, 10, 40);
        random_mix(80);

        // Wider lags: one frame needs 129 buffered samples.
        new_phase(700, 40, 30, 64);
        repeat (130) send_req(REQ_PUSH, next_sample());
        repeat (30) send_req(REQ_PULL, '0);

        // End of input; later pushes and ends are ignored and the tail is dropped.
        send_req(REQ_END, '0);
        send_req(REQ_PUSH, 16'sh1234);
        repeat (20) send_req(REQ_PULL, '0);
        send_req(REQ_END, '0);
        send_req(2'd3, '0);
        send_req(REQ_PULL, '0);

        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d pushes (%0d bounced on a full window), %0d pulls, %0d frames",
                 sb.n_push, sb.n_full, sb.n_pull, sb.n_frames);
        $display("over seven register settings; %0d result beats checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
